// ===== design/effect_source_tokenizer_top_assert.svh =====
// assertion macros used by the tokenizer lexer module
`ifndef EFFECT_SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define EFFECT_SOURCE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define EST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define EST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ===== design/est_pkg.sv =====
`default_nettype none

package est_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LINE_BITS_DEF   = 24;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte current_byte;
        t_byte lookahead_byte;
        logic  first_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [2:0]  token_kind;
        t_byte       char_value;
        logic        carries_char;
        logic [31:0] byte_offset;
        logic [23:0] line_number;
        logic [2:0]  error_code;
        logic        failed_so_far;
    } t_out_word;

    // event kinds
    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_APPEND = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // token kinds
    localparam logic [2:0] TK_COMMENT = 3'd0;
    localparam logic [2:0] TK_PREPROC = 3'd1;
    localparam logic [2:0] TK_IDENT   = 3'd2;
    localparam logic [2:0] TK_DELIM   = 3'd3;
    localparam logic [2:0] TK_STRING  = 3'd4;
    localparam logic [2:0] TK_NUMERIC = 3'd5;

    // error codes
    localparam logic [2:0] ER_NONE       = 3'd0;
    localparam logic [2:0] ER_NON_ASCII  = 3'd1;
    localparam logic [2:0] ER_UNRECOG    = 3'd2;
    localparam logic [2:0] ER_AFTER_SLSH = 3'd3;
    localparam logic [2:0] ER_PREPROC    = 3'd4;
    localparam logic [2:0] ER_IDENT      = 3'd5;
    localparam logic [2:0] ER_NUMBER     = 3'd6;

    // characters
    localparam t_byte CH_NUL    = 8'h00;
    localparam t_byte CH_HASH   = 8'h23;
    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_DOT    = 8'h2E;
    localparam t_byte CH_SEMI   = 8'h3B;
    localparam t_byte CH_UNDER  = 8'h5F;
    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_QUOTE  = 8'h22;
    localparam t_byte CH_LPAREN = 8'h28;
    localparam t_byte CH_RPAREN = 8'h29;
    localparam t_byte CH_LBRACE = 8'h7B;
    localparam t_byte CH_RBRACE = 8'h7D;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_CR     = 8'h0D;

endpackage

`default_nettype wire

// ===== design/effect_source_tokenizer_top.sv =====
`default_nettype none

// Byte-serial source lexer. Each input word is one source byte with a one-byte
// lookahead; it yields zero or one event word (token start, appended character
// or lexical error) stamped with the byte offset and line number of that byte.
// A word passes through an input register and the lexer state machine into an
// output register, so with the output side ready one byte is taken every clock
// and its event goes from the input register to the output register; updating
// the lexer mode and counters bounds the rate. Bytes raising no event are still
// consumed and counted. Counters are OFFSET_BITS and LINE_BITS wide and
// saturate; first_of_buffer restarts mode, counters and the sticky failure flag.

module effect_source_tokenizer_top #(
    parameter int OFFSET_BITS = est_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = est_pkg::LINE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire est_pkg::t_in_word  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output est_pkg::t_out_word      o_out_data
);
    import est_pkg::*;

    logic     stage_valid;
    logic     stage_take;
    t_in_word stage_data;

    est_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_stage_valid (stage_valid),
        .o_stage_data  (stage_data),
        .i_stage_take  (stage_take)
    );

    est_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage_valid (stage_valid),
        .i_stage_data  (stage_data),
        .o_stage_take  (stage_take),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire

// ===== design/est_in_stage.sv =====
`default_nettype none

module est_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire est_pkg::t_in_word i_in_data,
    output logic                   o_stage_valid,
    output est_pkg::t_in_word      o_stage_data,
    input  wire logic              i_stage_take
);
    import est_pkg::*;

    logic     r_valid;
    t_in_word r_data;

    assign o_in_ready    = !r_valid || i_stage_take;
    assign o_stage_valid = r_valid;
    assign o_stage_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/est_lexer.sv =====
`default_nettype none

module est_lexer #(
    parameter int OFFSET_BITS = est_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = est_pkg::LINE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_stage_valid,
    input  wire est_pkg::t_in_word i_stage_data,
    output logic                   o_stage_take,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output est_pkg::t_out_word     o_out_data
);
    import est_pkg::*;

    `include "effect_source_tokenizer_top_assert.svh"

    typedef enum logic [4:0] {
        M_NORMAL, M_SLASH, M_LINE_NEW, M_LINE_BODY, M_BLOCK_NEW, M_BLOCK_BODY,
        M_BLOCK_STAR, M_PRE_NEW, M_PRE_BODY, M_ID_NEW, M_ID_BODY, M_DELIM,
        M_STR_NEW, M_STR_BODY, M_STR_ESC, M_NUM_NEW, M_NUM_BODY, M_ERROR
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

    function automatic logic is_digit(input t_byte c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input t_byte c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_word_start(input t_byte c);
        return is_letter(c) || c == CH_UNDER;
    endfunction

    function automatic t_byte translate(input t_byte c);
        t_byte r;
        case (c)
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h66:   r = 8'd12;
            8'h6E:   r = 8'd10;
            8'h72:   r = 8'd13;
            8'h74:   r = 8'd9;
            8'h76:   r = 8'd11;
            8'h30:   r = 8'd0;
            default: r = c;
        endcase
        return r;
    endfunction

    t_mode                  r_mode, n_mode, mode_base;
    logic [LINE_BITS-1:0]   r_line, n_line, line_base;
    logic [OFFSET_BITS-1:0] r_pos, n_pos, pos_base;
    logic                   r_fail, n_fail, fail_base;
    logic                   r_out_valid;
    t_out_word              r_out;

    logic      adv;
    t_byte     c, pk, chr;
    logic      ev_on, has, is_delim, is_space, is_slash, common;
    logic [1:0] kind;
    logic [2:0] tok, err;
    t_mode     cm_mode;
    t_out_word ev;
    logic [63:0] off_ext;
    logic [31:0] line_ext;

    assign o_stage_take = !r_out_valid || i_out_ready;
    assign adv          = i_stage_valid && o_stage_take;
    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out;

    assign c  = i_stage_data.current_byte;
    assign pk = i_stage_data.lookahead_byte;

    // counters, mode and failure flag, with restart at the head of a buffer
    always_comb begin
        mode_base = i_stage_data.first_of_buffer ? M_NORMAL : r_mode;
        line_base = i_stage_data.first_of_buffer ? LINE_BITS'(1) : r_line;
        pos_base  = i_stage_data.first_of_buffer ? '0 : r_pos;
        fail_base = i_stage_data.first_of_buffer ? 1'b0 : r_fail;
        n_line    = (c == CH_NL && line_base != LINE_MAX) ? line_base + LINE_BITS'(1)
                                                          : line_base;
        n_pos     = (pos_base != OFF_MAX) ? pos_base + OFFSET_BITS'(1) : pos_base;
        off_ext   = 64'(pos_base);
        line_ext  = 32'(n_line);
    end

    always_comb begin
        is_delim = c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
                   c == CH_LBRACE || c == CH_RBRACE || c == CH_COMMA;
        is_slash = c == CH_SLASH;
        is_space = c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
        common   = is_delim || is_slash || is_space;
        cm_mode  = is_delim ? M_DELIM : (is_slash ? M_SLASH : M_NORMAL);

        n_mode = mode_base;
        ev_on  = 1'b0;
        kind   = EV_APPEND;
        tok    = TK_COMMENT;
        has    = 1'b1;
        chr    = c;
        err    = ER_NONE;

        if (c == CH_NUL) begin
            n_mode = M_NORMAL;
        end else if (c[7]) begin
            err = ER_NON_ASCII;
        end else begin
            case (mode_base)
                M_SLASH: begin
                    if (c == CH_SLASH || c == CH_STAR) begin
                        n_mode = (c == CH_SLASH) ? M_LINE_NEW : M_BLOCK_NEW;
                        ev_on  = 1'b1;
                        kind   = EV_START;
                        has    = 1'b0;
                    end else begin
                        err = ER_AFTER_SLSH;
                    end
                end
                M_LINE_NEW, M_LINE_BODY: begin
                    if (c == CH_NL) begin
                        n_mode = M_NORMAL;
                    end else begin
                        n_mode = M_LINE_BODY;
                        ev_on  = 1'b1;
                    end
                end
                M_BLOCK_NEW, M_BLOCK_BODY: begin
                    if (c == CH_STAR && pk == CH_SLASH) begin
                        n_mode = M_BLOCK_STAR;
                    end else begin
                        n_mode = M_BLOCK_BODY;
                        ev_on  = 1'b1;
                    end
                end
                M_BLOCK_STAR: begin
                    n_mode = M_NORMAL;
                end
                M_PRE_NEW, M_ID_NEW, M_NUM_NEW: begin
                    tok = (mode_base == M_PRE_NEW) ? TK_PREPROC :
                          (mode_base == M_ID_NEW)  ? TK_IDENT : TK_NUMERIC;
                    if (common) begin
                        n_mode = cm_mode;
                        ev_on  = is_delim;
                        kind   = EV_START;
                        tok    = TK_DELIM;
                    end else begin
                        n_mode = (mode_base == M_PRE_NEW) ? M_PRE_BODY :
                                 (mode_base == M_ID_NEW)  ? M_ID_BODY : M_NUM_BODY;
                        ev_on  = 1'b1;
                    end
                end
                M_PRE_BODY, M_ID_BODY, M_NUM_BODY: begin
                    tok = (mode_base == M_PRE_BODY) ? TK_PREPROC :
                          (mode_base == M_ID_BODY)  ? TK_IDENT : TK_NUMERIC;
                    if ((mode_base == M_PRE_BODY && is_letter(c)) ||
                        (mode_base == M_ID_BODY && (is_word_start(c) || is_digit(c))) ||
                        (mode_base == M_NUM_BODY && (is_digit(c) || c == CH_DOT))) begin
                        ev_on = 1'b1;
                    end else if (common) begin
                        n_mode = cm_mode;
                        ev_on  = is_delim;
                        kind   = EV_START;
                        tok    = TK_DELIM;
                    end else begin
                        err = (mode_base == M_PRE_BODY) ? ER_PREPROC :
                              (mode_base == M_ID_BODY)  ? ER_IDENT : ER_NUMBER;
                    end
                end
                M_STR_NEW, M_STR_BODY: begin
                    tok = TK_STRING;
                    if (c == CH_BSLASH) begin
                        n_mode = M_STR_ESC;
                    end else if (c == CH_QUOTE) begin
                        n_mode = M_NORMAL;
                    end else begin
                        n_mode = M_STR_BODY;
                        ev_on  = 1'b1;
                    end
                end
                M_STR_ESC: begin
                    n_mode = M_STR_BODY;
                    ev_on  = 1'b1;
                    tok    = TK_STRING;
                    chr    = translate(c);
                end
                M_ERROR: begin
                    n_mode = M_NORMAL;
                end
                default: begin
                    kind  = EV_START;
                    ev_on = 1'b1;
                    if (common) begin
                        n_mode = cm_mode;
                        ev_on  = is_delim;
                        tok    = TK_DELIM;
                    end else if (c == CH_HASH) begin
                        n_mode = M_PRE_NEW;
                        tok    = TK_PREPROC;
                        has    = 1'b0;
                    end else if (c == CH_QUOTE) begin
                        n_mode = M_STR_NEW;
                        tok    = TK_STRING;
                        has    = 1'b0;
                    end else if (is_word_start(c)) begin
                        n_mode = M_ID_NEW;
                        tok    = TK_IDENT;
                    end else if (is_digit(c)) begin
                        n_mode = M_NUM_NEW;
                        tok    = TK_NUMERIC;
                    end else begin
                        ev_on = 1'b0;
                        err   = ER_UNRECOG;
                    end
                end
            endcase
        end

        if (err != ER_NONE) begin
            n_mode = M_ERROR;
            ev_on  = 1'b1;
        end
        n_fail = fail_base || (err != ER_NONE);

        ev.event_kind    = (err != ER_NONE) ? EV_ERROR : kind;
        ev.token_kind    = (err != ER_NONE) ? TK_COMMENT : tok;
        ev.carries_char  = (err == ER_NONE) && has;
        ev.char_value    = ((err == ER_NONE) && has) ? chr : CH_NUL;
        ev.byte_offset   = off_ext[31:0];
        ev.line_number   = line_ext[23:0];
        ev.error_code    = err;
        ev.failed_so_far = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NORMAL;
            r_line      <= LINE_BITS'(1);
            r_pos       <= '0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_mode      <= n_mode;
            r_line      <= n_line;
            r_pos       <= n_pos;
            r_fail      <= n_fail;
            r_out_valid <= ev_on;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && ev_on) begin
            r_out <= ev;
        end
    end

    `EST_ASSERT_NOW(a_err_word_flags, r_out_valid && r_out.event_kind == EV_ERROR,
        r_out.failed_so_far && !r_out.carries_char && r_out.error_code != ER_NONE)
    `EST_ASSERT_NOW(a_char_zero, r_out_valid && !r_out.carries_char,
        r_out.char_value == CH_NUL)
    `EST_ASSERT_NOW(a_fail_sticky, adv && r_fail && !n_fail,
        i_stage_data.first_of_buffer)
    `EST_ASSERT_NEXT(a_err_mode, adv && err != ER_NONE,
        r_mode == M_ERROR && r_fail && r_out_valid)
    `EST_ASSERT_NOW(a_line_nonzero, 1'b1, r_line != '0)

endmodule

`default_nettype wire

// ===== sim/effect_source_tokenizer_checker.sv =====
module effect_source_tokenizer_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire est_pkg::t_in_word  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire est_pkg::t_out_word i_out_data,
    output int                      o_mismatches,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import est_pkg::*;

    typedef enum logic [4:0] {
        LX_NORMAL, LX_SLASH, LX_LINE_NEW, LX_LINE_BODY, LX_BLOCK_NEW, LX_BLOCK_BODY,
        LX_BLOCK_STAR, LX_PRE_NEW, LX_PRE_BODY, LX_ID_NEW, LX_ID_BODY, LX_DELIM,
        LX_STR_NEW, LX_STR_BODY, LX_STR_ESC, LX_NUM_NEW, LX_NUM_BODY, LX_ERROR
    } t_lex_mode;

    t_lex_mode   lex_mode     = LX_NORMAL;
    logic [23:0] line_count   = 24'd1;
    logic [31:0] byte_pos     = '0;
    logic        sticky_fail  = 1'b0;
    bit          event_raised;
    t_out_word   event_word;

    t_out_word   expected_events[$];
    int          mismatch_count = 0;
    int          pending_count  = 0;
    int          events_seen    = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    function automatic bit is_digit(t_byte c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(t_byte c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word_start(t_byte c);
        return is_letter(c) || c == CH_UNDER;
    endfunction

    function automatic bit is_delim(t_byte c);
        return c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE
            || c == CH_RBRACE || c == CH_COMMA;
    endfunction

    function automatic bit is_space(t_byte c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    function automatic t_byte unescape(t_byte c);
        case (c)
            "a": return 8'h07;
            "b": return 8'h08;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            "v": return 8'h0B;
            "0": return 8'h00;
            default: return c;
        endcase
    endfunction

    function automatic void put_event(logic [1:0] kind, logic [2:0] tok, logic has, t_byte ch,
                                      logic [2:0] err);
        event_raised            = 1'b1;
        event_word              = '0;
        event_word.event_kind   = kind;
        event_word.token_kind   = tok;
        event_word.carries_char = has;
        event_word.char_value   = has ? ch : CH_NUL;
        event_word.error_code   = err;
    endfunction

    // token kind field reads TK_COMMENT on errors
    function automatic void lex_error(logic [2:0] code);
        lex_mode    = LX_ERROR;
        sticky_fail = 1'b1;
        put_event(EV_ERROR, TK_COMMENT, 1'b0, CH_NUL, code);
    endfunction

    function automatic bit shared_move(t_byte c);
        if (is_delim(c)) begin
            lex_mode = LX_DELIM;
            put_event(EV_START, TK_DELIM, 1'b1, c, ER_NONE);
            return 1'b1;
        end
        if (c == CH_SLASH) begin
            lex_mode = LX_SLASH;
            return 1'b1;
        end
        if (is_space(c)) begin
            lex_mode = LX_NORMAL;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void classify(t_byte c);
        if (shared_move(c))
            return;
        if (c == CH_HASH) begin
            lex_mode = LX_PRE_NEW;
            put_event(EV_START, TK_PREPROC, 1'b0, CH_NUL, ER_NONE);
        end else if (c == CH_QUOTE) begin
            lex_mode = LX_STR_NEW;
            put_event(EV_START, TK_STRING, 1'b0, CH_NUL, ER_NONE);
        end else if (is_word_start(c)) begin
            lex_mode = LX_ID_NEW;
            put_event(EV_START, TK_IDENT, 1'b1, c, ER_NONE);
        end else if (is_digit(c)) begin
            lex_mode = LX_NUM_NEW;
            put_event(EV_START, TK_NUMERIC, 1'b1, c, ER_NONE);
        end else begin
            lex_error(ER_UNRECOG);
        end
    endfunction

    function automatic bit lex_byte(input t_in_word w, output t_out_word res);
        t_byte       c;
        t_byte       la;
        logic [23:0] line_now;
        logic [31:0] off_now;
        c  = w.current_byte;
        la = w.lookahead_byte;
        if (w.first_of_buffer) begin
            lex_mode    = LX_NORMAL;
            line_count  = 24'd1;
            byte_pos    = '0;
            sticky_fail = 1'b0;
        end
        if (c == CH_NL && line_count != '1)
            line_count = line_count + 1'b1;
        line_now = line_count;
        off_now  = byte_pos;
        if (byte_pos != '1)
            byte_pos = byte_pos + 1'b1;

        event_raised = 1'b0;
        event_word   = '0;
        if (c == CH_NUL) begin
            lex_mode = LX_NORMAL;
        end else if (c[7]) begin
            lex_error(ER_NON_ASCII);
        end else begin
            case (lex_mode)
                LX_SLASH: begin
                    if (c == CH_SLASH) begin
                        lex_mode = LX_LINE_NEW;
                        put_event(EV_START, TK_COMMENT, 1'b0, CH_NUL, ER_NONE);
                    end else if (c == CH_STAR) begin
                        lex_mode = LX_BLOCK_NEW;
                        put_event(EV_START, TK_COMMENT, 1'b0, CH_NUL, ER_NONE);
                    end else begin
                        lex_error(ER_AFTER_SLSH);
                    end
                end
                LX_LINE_NEW, LX_LINE_BODY: begin
                    if (c == CH_NL) begin
                        lex_mode = LX_NORMAL;
                    end else begin
                        lex_mode = LX_LINE_BODY;
                        put_event(EV_APPEND, TK_COMMENT, 1'b1, c, ER_NONE);
                    end
                end
                LX_BLOCK_NEW, LX_BLOCK_BODY: begin
                    if (c == CH_STAR && la == CH_SLASH) begin
                        lex_mode = LX_BLOCK_STAR;
                    end else begin
                        lex_mode = LX_BLOCK_BODY;
                        put_event(EV_APPEND, TK_COMMENT, 1'b1, c, ER_NONE);
                    end
                end
                LX_BLOCK_STAR: lex_mode = LX_NORMAL;
                LX_PRE_NEW: begin
                    if (!shared_move(c)) begin
                        lex_mode = LX_PRE_BODY;
                        put_event(EV_APPEND, TK_PREPROC, 1'b1, c, ER_NONE);
                    end
                end
                LX_PRE_BODY: begin
                    if (is_letter(c))
                        put_event(EV_APPEND, TK_PREPROC, 1'b1, c, ER_NONE);
                    else if (!shared_move(c))
                        lex_error(ER_PREPROC);
                end
                LX_ID_NEW: begin
                    if (!shared_move(c)) begin
                        lex_mode = LX_ID_BODY;
                        put_event(EV_APPEND, TK_IDENT, 1'b1, c, ER_NONE);
                    end
                end
                LX_ID_BODY: begin
                    if (is_word_start(c) || is_digit(c))
                        put_event(EV_APPEND, TK_IDENT, 1'b1, c, ER_NONE);
                    else if (!shared_move(c))
                        lex_error(ER_IDENT);
                end
                LX_STR_NEW, LX_STR_BODY: begin
                    if (c == CH_BSLASH) begin
                        lex_mode = LX_STR_ESC;
                    end else if (c == CH_QUOTE) begin
                        lex_mode = LX_NORMAL;
                    end else begin
                        lex_mode = LX_STR_BODY;
                        put_event(EV_APPEND, TK_STRING, 1'b1, c, ER_NONE);
                    end
                end
                LX_STR_ESC: begin
                    lex_mode = LX_STR_BODY;
                    put_event(EV_APPEND, TK_STRING, 1'b1, unescape(c), ER_NONE);
                end
                LX_NUM_NEW: begin
                    if (!shared_move(c)) begin
                        lex_mode = LX_NUM_BODY;
                        put_event(EV_APPEND, TK_NUMERIC, 1'b1, c, ER_NONE);
                    end
                end
                LX_NUM_BODY: begin
                    if (is_digit(c) || c == CH_DOT)
                        put_event(EV_APPEND, TK_NUMERIC, 1'b1, c, ER_NONE);
                    else if (!shared_move(c))
                        lex_error(ER_NUMBER);
                end
                LX_ERROR: lex_mode = LX_NORMAL;
                default: classify(c);
            endcase
        end

        res               = event_word;
        res.byte_offset   = off_now;
        res.line_number   = line_now;
        res.failed_so_far = sticky_fail;
        return event_raised;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < 200)
            $display("mismatch at event word %0d, %s: got %h, want %h",
                     events_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word predicted;
        t_out_word want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("word with nothing expected", 32'd0, 32'd0);
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_data.event_kind !== want.event_kind)
                        report_mismatch("event_kind", 32'(i_out_data.event_kind),
                                        32'(want.event_kind));
                    if (i_out_data.token_kind !== want.token_kind)
                        report_mismatch("token_kind", 32'(i_out_data.token_kind),
                                        32'(want.token_kind));
                    if (i_out_data.char_value !== want.char_value)
                        report_mismatch("char_value", 32'(i_out_data.char_value),
                                        32'(want.char_value));
                    if (i_out_data.carries_char !== want.carries_char)
                        report_mismatch("carries_char", 32'(i_out_data.carries_char),
                                        32'(want.carries_char));
                    if (i_out_data.byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", i_out_data.byte_offset, want.byte_offset);
                    if (i_out_data.line_number !== want.line_number)
                        report_mismatch("line_number", 32'(i_out_data.line_number),
                                        32'(want.line_number));
                    if (i_out_data.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(i_out_data.error_code),
                                        32'(want.error_code));
                    if (i_out_data.failed_so_far !== want.failed_so_far)
                        report_mismatch("failed_so_far", 32'(i_out_data.failed_so_far),
                                        32'(want.failed_so_far));
                end
                events_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                if (lex_byte(i_in_data, predicted))
                    expected_events.insert(expected_events.size(), predicted);
            end
        end
        pending_count = expected_events.size();
    end

endmodule

// ===== sim/tb_effect_source_tokenizer_top.sv =====
module tb_effect_source_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import est_pkg::*;

    localparam int RANDOM_WORDS   = 650;
    localparam int PHASE_TWO_AT   = 230;
    localparam int PHASE_THREE_AT = 460;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 200000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;

    int    mismatches;
    int    pending;
    int    send_idle_pct = 36;
    int    recv_idle_pct = 58;
    int    words_sent    = 0;
    int    hold_left     = 0;
    bit    hold_done     = 1'b0;
    int    cycle_count   = 0;
    int    phase         = 1;
    t_byte src_text[$];

    effect_source_tokenizer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    effect_source_tokenizer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic void add_byte(t_byte b);
        src_text.insert(src_text.size(), b);
    endfunction

    function automatic t_byte rand_letter();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? t_byte'("a" + n) : t_byte'("A" + n - 26);
    endfunction

    function automatic t_byte rand_digit();
        return t_byte'("0" + $urandom_range(0, 9));
    endfunction

    function automatic t_byte rand_word_char();
        case ($urandom_range(0, 2))
            0: return rand_letter();
            1: return rand_digit();
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic t_byte rand_printable();
        return t_byte'($urandom_range(32, 126));
    endfunction

    function automatic void add_fragment();
        string delims;
        string spaces;
        string escapes;
        string unknown;
        t_byte ch;
        delims  = ";(){},";
        spaces  = " \t\r\n";
        escapes = "abfnrtv0q\\\"";
        unknown = "!?@$%&`~";
        case ($urandom_range(0, 15))
            0, 1: begin
                add_byte(($urandom_range(0, 3) == 0) ? CH_UNDER : rand_letter());
                repeat ($urandom_range(0, 5)) add_byte(rand_word_char());
            end
            2: begin
                add_byte(rand_digit());
                repeat ($urandom_range(0, 4))
                    add_byte(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit());
            end
            3: add_byte(delims[$urandom_range(0, 5)]);
            4: add_byte(spaces[$urandom_range(0, 3)]);
            5: add_byte(CH_NL);
            6: begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                repeat ($urandom_range(0, 6)) add_byte(rand_printable());
                add_byte(CH_NL);
            end
            7: begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                repeat ($urandom_range(0, 6))
                    add_byte(($urandom_range(0, 3) == 0) ? CH_STAR : rand_printable());
                add_byte(CH_STAR);
                add_byte(CH_SLASH);
            end
            8, 9: begin
                add_byte(CH_QUOTE);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 2) == 0) begin
                        add_byte(CH_BSLASH);
                        add_byte(escapes[$urandom_range(0, 10)]);
                    end else begin
                        ch = rand_printable();
                        add_byte((ch == CH_QUOTE || ch == CH_BSLASH) ? t_byte'("z") : ch);
                    end
                end
                add_byte(CH_QUOTE);
            end
            10: begin
                add_byte(CH_HASH);
                repeat ($urandom_range(0, 5)) add_byte(rand_letter());
            end
            11: begin
                // broken tokens
                case ($urandom_range(0, 4))
                    0: begin
                        add_byte(CH_SLASH);
                        add_byte(rand_letter());
                    end
                    1: begin
                        add_byte(CH_HASH);
                        add_byte(rand_letter());
                        add_byte(rand_digit());
                    end
                    2: begin
                        add_byte(rand_letter());
                        add_byte(rand_letter());
                        add_byte(unknown[$urandom_range(0, 7)]);
                    end
                    3: begin
                        add_byte(rand_digit());
                        add_byte(rand_digit());
                        add_byte(rand_letter());
                    end
                    default: add_byte(unknown[$urandom_range(0, 7)]);
                endcase
                add_byte(rand_printable());
            end
            12: add_byte(t_byte'($urandom_range(128, 255)));
            13: add_byte(CH_NUL);
            14: add_byte(t_byte'($urandom_range(1, 127)));
            default: add_byte(t_byte'($urandom_range(0, 255)));
        endcase
    endfunction

    task automatic send_word(t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(bit fresh);
        t_in_word w;
        for (int i = 0; i < src_text.size(); i++) begin
            w.current_byte   = src_text[i];
            w.lookahead_byte = (i + 1 < src_text.size()) ? src_text[i + 1] : CH_NUL;
            if ($urandom_range(0, 99) < 8)
                w.lookahead_byte = t_byte'($urandom_range(0, 255));
            w.first_of_buffer = fresh && (i == 0);
            send_word(w);
        end
        src_text.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial begin : stimulus
        string directed_src;
        bit    fresh;
        directed_src = "#d;x9 4.\"\\tz\"/**/q//c\n";
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < directed_src.len(); i++)
            add_byte(directed_src[i]);
        add_byte(8'hFF);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_byte(CH_NUL);
        send_text(1'b1);

        while (words_sent < RANDOM_WORDS) begin
            if (phase == 1 && words_sent >= PHASE_TWO_AT) begin
                wait_drained();
                send_idle_pct = 58;
                recv_idle_pct = 36;
                phase = 2;
            end else if (phase == 2 && words_sent >= PHASE_THREE_AT) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                phase = 3;
            end
            fresh = ($urandom_range(0, 99) < 85);
            repeat ($urandom_range(1, 8)) add_fragment();
            send_text(fresh);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== effect_source_tokenizer_top.f =====
+incdir+design
design/est_pkg.sv
design/est_in_stage.sv
design/est_lexer.sv
design/effect_source_tokenizer_top.sv
sim/effect_source_tokenizer_checker.sv
sim/tb_effect_source_tokenizer_top.sv
